/* hw/rtl/pidaw_pkg.sv */
package pidaw_pkg;

    typedef struct packed {
        logic signed [15:0] process_value;
        logic        [15:0] elapsed_ms;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] control_value;
        logic        [7:0]  drive_byte;
    } t_out_beat;

    typedef enum logic [2:0] {
        CFG_SET_POINT   = 3'd0,
        CFG_GAIN_P      = 3'd1,
        CFG_GAIN_I      = 3'd2,
        CFG_GAIN_D      = 3'd3,
        CFG_INT_UPPER   = 3'd4,
        CFG_INT_LOWER   = 3'd5,
        CFG_OUT_UPPER   = 3'd6,
        CFG_OUT_LOWER   = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INTEG,
        ST_MULD,
        ST_DIV,
        ST_MULP,
        ST_MULI,
        ST_FINISH,
        ST_OUT
    } t_state;

    localparam int DivW = 58;

endpackage

/* hw/rtl/pid_controller_anti_windup_core.sv */
// From an input beat to o_valid the core steps through the integral multiply, the
// derivative multiply, the divide (skipped for zero elapsed_ms), the P multiply and the
// I multiply, one multiplier or quotient bit at a time, then the finish state.
// A new sample is taken only in ST_IDLE, once the previous result has been taken; output stalls hold ST_OUT.
// Reset (i_rst_n low, synchronous): registers take their reset values,
// integral and previous error clear, output idle.
module pid_controller_anti_windup_core
    import pidaw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in_beat         i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_beat        o_data,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [39:0]      i_cfg_data
);

    // configuration registers
    logic signed [15:0] r_sp, r_kp, r_ki, r_kd, r_ou, r_ol;
    logic signed [39:0] r_iu, r_il;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0; r_kp <= '0; r_ki <= '0; r_kd <= '0;
            r_iu <= '0; r_il <= '0; r_ou <= 16'sd102; r_ol <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SET_POINT: r_sp <= i_cfg_data[15:0];
                CFG_GAIN_P:    r_kp <= i_cfg_data[15:0];
                CFG_GAIN_I:    r_ki <= i_cfg_data[15:0];
                CFG_GAIN_D:    r_kd <= i_cfg_data[15:0];
                CFG_INT_UPPER: r_iu <= i_cfg_data;
                CFG_INT_LOWER: r_il <= i_cfg_data;
                CFG_OUT_UPPER: r_ou <= i_cfg_data[15:0];
                CFG_OUT_LOWER: r_ol <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    t_state r_st, n_st;
    logic signed [39:0] r_isum;
    logic signed [16:0] r_perr, r_err;
    logic        [15:0] r_ms;
    logic        [6:0]  r_cnt;
    // shift-add multiplier: multiplicand (signed, wide), multiplier shifted out lsb first
    logic signed [57:0] r_mcand;
    logic        [39:0] r_mplier;
    logic signed [57:0] r_acc;
    logic               r_mneg;
    // divider
    logic        [57:0] r_quo;
    logic        [16:0] r_rem;
    logic               r_dneg;
    logic signed [59:0] r_sum;
    t_out_beat          r_out;

    logic signed [17:0] w_de;
    logic signed [40:0] w_s;
    logic        [16:0] w_rtry;
    logic signed [57:0] w_addend;
    logic               w_done_mul;

    assign w_de = 18'(r_err) - 18'(r_perr);
    assign w_s  = 41'(r_isum) + 41'(r_acc);
    assign w_rtry = {r_rem[15:0], r_quo[57]} - {1'b0, r_ms};
    assign w_addend = r_mplier[0] ? r_mcand : 58'sd0;
    assign w_done_mul = (r_cnt == 7'd0);

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:   if (i_valid) n_st = ST_INTEG;
            ST_INTEG:  if (w_done_mul) n_st = ST_MULD;
            ST_MULD:   if (w_done_mul) n_st = (r_ms == '0) ? ST_MULP : ST_DIV;
            ST_DIV:    if (w_done_mul) n_st = ST_MULP;
            ST_MULP:   if (w_done_mul) n_st = ST_MULI;
            ST_MULI:   if (w_done_mul) n_st = ST_FINISH;
            ST_FINISH: n_st = ST_OUT;
            ST_OUT:    if (!i_stall) n_st = ST_IDLE;
            default:   n_st = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_stall = (r_st != ST_IDLE);
        o_valid = (r_st == ST_OUT);
        o_data  = r_out;
    end

    // final rounding and clamp of the summed terms
    logic signed [59:0] w_fsum;
    logic signed [59:0] w_up, w_lo;
    logic        [59:0] w_mag;
    logic signed [47:0] w_rnd;
    logic signed [15:0] w_ctl;
    logic        [17:0] w_drv;
    always_comb begin
        w_fsum = r_sum;
        w_up   = {{32{r_ou[15]}}, r_ou, 12'd0};
        w_lo   = {{32{r_ol[15]}}, r_ol, 12'd0};
        w_mag  = w_fsum[59] ? 60'(-w_fsum) : 60'(w_fsum);
        w_rnd  = 48'((w_mag + 60'd2048) >> 12);
        if (w_fsum > w_up)      w_ctl = r_ou;
        else if (w_fsum < w_lo) w_ctl = r_ol;
        else                    w_ctl = w_fsum[59] ? 16'(-w_rnd) : 16'(w_rnd);
        w_drv = 18'(({{2{w_ctl[15]}}, w_ctl} <<< 2) + {{2{w_ctl[15]}}, w_ctl} + 18'sd1) >>> 1;
    end

    // datapath sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_isum <= '0;
            r_perr <= '0;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                ST_IDLE: if (i_valid) begin
                    r_err  <= 17'(r_sp) - 17'(i_data.process_value);
                    r_ms   <= i_data.elapsed_ms;
                    r_mcand <= 58'(17'(r_sp) - 17'(i_data.process_value));
                    r_mplier <= 40'(i_data.elapsed_ms);
                    r_acc  <= '0;
                    r_cnt  <= 7'd15;
                    r_mneg <= 1'b0;
                end
                ST_INTEG: begin
                    r_acc <= r_acc + w_addend;
                    r_mcand <= r_mcand <<< 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt <= r_cnt - 7'd1;
                    if (w_done_mul) begin
                        if (w_s + 41'(w_addend) > 41'(r_iu)) r_isum <= r_iu;
                        else if (w_s + 41'(w_addend) < 41'(r_il)) r_isum <= r_il;
                        else r_isum <= 40'(w_s + 41'(w_addend));
                        // derivative numerator: kd*1000 (as 1024-16-8) times |de|
                        r_mcand <= (58'(r_kd) <<< 10) - (58'(r_kd) <<< 4)
                                 - (58'(r_kd) <<< 3);
                        r_mplier <= 40'(w_de[17] ? -w_de : w_de);
                        r_mneg  <= w_de[17];
                        r_acc   <= '0;
                        r_cnt   <= 7'd17;
                    end
                end
                ST_MULD: begin
                    r_acc <= r_acc + w_addend;
                    r_mcand <= r_mcand <<< 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt <= r_cnt - 7'd1;
                    if (w_done_mul) begin
                        // (2|num|+ms)/(2ms) equals (|num| + floor(ms/2))/ms
                        r_sum <= '0;
                        r_dneg <= ((r_acc + w_addend) < 0) ^ r_mneg;
                        r_quo <= 58'((((r_acc + w_addend) < 0) ? -(r_acc + w_addend)
                                     : (r_acc + w_addend)) + 58'(r_ms >> 1));
                        r_rem <= '0;
                        r_cnt <= 7'(DivW - 1);
                    end
                end
                ST_DIV: begin
                    // restoring divide by ms, half of ms pre-added for rounding
                    r_rem <= w_rtry[16] ? {r_rem[15:0], r_quo[57]} : w_rtry;
                    r_quo <= {r_quo[56:0], ~w_rtry[16]};
                    r_cnt <= r_cnt - 7'd1;
                    if (w_done_mul) begin
                        r_sum <= r_dneg ? -60'({r_quo[56:0], ~w_rtry[16]})
                                        : 60'({r_quo[56:0], ~w_rtry[16]});
                    end
                end
                default: ;
            endcase
            if ((r_st == ST_MULD && w_done_mul && r_ms == '0) ||
                (r_st == ST_DIV && w_done_mul)) begin
                r_mcand <= 58'(r_kp);
                r_mplier <= 40'(r_err[16] ? -r_err : r_err);
                r_mneg <= r_err[16];
                r_acc <= '0;
                r_cnt <= 7'd17;
                if (r_st == ST_MULD) r_sum <= '0;
            end
            if (r_st == ST_MULP) begin
                r_acc <= r_acc + w_addend;
                r_mcand <= r_mcand <<< 1;
                r_mplier <= r_mplier >> 1;
                r_cnt <= r_cnt - 7'd1;
                if (w_done_mul) begin
                    r_sum <= r_sum + (r_mneg ? -60'(r_acc + w_addend) : 60'(r_acc + w_addend));
                    r_mcand <= 58'(r_ki);
                    r_mplier <= r_isum[39] ? 40'(-r_isum) : r_isum;
                    r_mneg <= r_isum[39];
                    r_acc <= '0;
                    r_cnt <= 7'd40;
                end
            end
            if (r_st == ST_MULI) begin
                r_acc <= r_acc + w_addend;
                r_mcand <= r_mcand <<< 1;
                r_mplier <= r_mplier >> 1;
                r_cnt <= r_cnt - 7'd1;
                if (w_done_mul)
                    r_sum <= r_sum + (r_mneg ? -60'(r_acc + w_addend) : 60'(r_acc + w_addend));
            end
            if (r_st == ST_FINISH) begin
                r_perr <= r_err;
                r_out.control_value <= w_ctl;
                r_out.drive_byte <= (w_ctl <= 0) ? 8'd0
                                  : (w_drv > 18'd255) ? 8'd255 : w_drv[7:0];
            end
        end
    end

    // an output beat only follows a completed computation
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_st) == ST_FINISH) else $error("beat without finish");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input taken while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_FINISH) |=> r_perr == $past(r_err)) else $error("prev error not updated");

endmodule
